// ===== sv/bis_pkg.sv =====
// ----------------------------------------------------------------------------
// bis_pkg
// Shared types, field widths and codes of the bilinear image scaler.
// ----------------------------------------------------------------------------
package bis_pkg;

   localparam int COORD_W      = 10;
   localparam int PIX_W        = 8;
   localparam int STEP_W       = 25;
   localparam int DIM_CFG_W    = 9;
   localparam int REQ_DATA_W   = 32;
   localparam int RSP_DATA_W   = 8;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 25;

   localparam int MAX_SRC_DIM_DEFAULT = 256;
   localparam int MAX_DST_DIM_DEFAULT = 1024;
   localparam int FRAC_BITS_DEFAULT   = 16;

   localparam logic [DIM_CFG_W-1:0] SRC_WIDTH_RESET  = 9'd256;
   localparam logic [DIM_CFG_W-1:0] SRC_HEIGHT_RESET = 9'd256;
   localparam logic [STEP_W-1:0]    X_STEP_RESET     = 25'd65536;
   localparam logic [STEP_W-1:0]    Y_STEP_RESET     = 25'd65536;

   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_SRC_WIDTH  = 2'd0,
      REG_SRC_HEIGHT = 2'd1,
      REG_X_STEP     = 2'd2,
      REG_Y_STEP     = 2'd3
   } csr_reg_type;

endpackage

// ===== sv/bis_locate.sv =====
// ----------------------------------------------------------------------------
// bis_locate
// Registered axis locator: base pixel, next pixel and blend fraction.
// ----------------------------------------------------------------------------
module bis_locate #(
   parameter int POS_W     = 35,
   parameter int IDX_W     = 8,
   parameter int FRAC_BITS = bis_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic [POS_W-1:0]     pos,
   input  logic [IDX_W-1:0]     last,
   output logic [IDX_W-1:0]     base,
   output logic [IDX_W-1:0]     nxt,
   output logic [FRAC_BITS-1:0] frac
);

   localparam int FL_W  = POS_W - FRAC_BITS;
   localparam int CMP_W = (FL_W > IDX_W) ? FL_W : IDX_W;

   logic [CMP_W-1:0]     floor_ext;
   logic [IDX_W-1:0]     base_in;
   logic [IDX_W-1:0]     nxt_in;
   logic [IDX_W-1:0]     base_ff;
   logic [IDX_W-1:0]     nxt_ff;
   logic [FRAC_BITS-1:0] frac_ff;

   always_comb begin
      floor_ext = CMP_W'(pos[POS_W-1:FRAC_BITS]);
      if (floor_ext > CMP_W'(last)) begin
         base_in = last;
      end else begin
         base_in = floor_ext[IDX_W-1:0];
      end
      if (base_in == last) begin
         nxt_in = base_in;
      end else begin
         nxt_in = base_in + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         base_ff <= base_in;
         nxt_ff  <= nxt_in;
         frac_ff <= pos[FRAC_BITS-1:0];
      end
   end

   assign base = base_ff;
   assign nxt  = nxt_ff;
   assign frac = frac_ff;

endmodule

// ===== sv/bis_frame_store.sv =====
// ----------------------------------------------------------------------------
// bis_frame_store
// Source frame store in four banks split by row and column parity, so the
// four neighbors of a sample point are read in the same cycle.
// ----------------------------------------------------------------------------
module bis_frame_store #(
   parameter int IDX_W = 8
) (
   input  logic                       clock,
   input  logic                       rd_en,
   input  logic [IDX_W-1:0]           rd_x0,
   input  logic [IDX_W-1:0]           rd_x1,
   input  logic [IDX_W-1:0]           rd_y0,
   input  logic [IDX_W-1:0]           rd_y1,
   input  logic                       wr_en,
   input  logic [IDX_W-1:0]           wr_x,
   input  logic [IDX_W-1:0]           wr_y,
   input  logic [bis_pkg::PIX_W-1:0]  wr_data,
   output logic [bis_pkg::PIX_W-1:0]  c00,
   output logic [bis_pkg::PIX_W-1:0]  c01,
   output logic [bis_pkg::PIX_W-1:0]  c10,
   output logic [bis_pkg::PIX_W-1:0]  c11
);

   localparam int HALF_W     = IDX_W - 1;
   localparam int ADDR_W     = 2 * HALF_W;
   localparam int BANK_DEPTH = 1 << ADDR_W;

   logic [bis_pkg::PIX_W-1:0] q_ff [4];
   logic                      x0p_ff;
   logic                      x1p_ff;
   logic                      y0p_ff;
   logic                      y1p_ff;
   logic [ADDR_W-1:0]         wr_addr;

   assign wr_addr = {wr_y[IDX_W-1:1], wr_x[IDX_W-1:1]};

   for (genvar by = 0; by < 2; by++) begin : g_row
      for (genvar bx = 0; bx < 2; bx++) begin : g_col
         logic [bis_pkg::PIX_W-1:0] mem [BANK_DEPTH];
         logic [IDX_W-1:0]          row;
         logic [IDX_W-1:0]          col;
         logic [ADDR_W-1:0]         rd_addr;

         always_comb begin
            row     = (rd_y0[0] == 1'(by)) ? rd_y0 : rd_y1;
            col     = (rd_x0[0] == 1'(bx)) ? rd_x0 : rd_x1;
            rd_addr = {row[IDX_W-1:1], col[IDX_W-1:1]};
         end

         always_ff @(posedge clock) begin
            if (wr_en && wr_y[0] == 1'(by) && wr_x[0] == 1'(bx)) begin
               mem[wr_addr] <= wr_data;
            end
            if (rd_en) begin
               q_ff[by*2+bx] <= mem[rd_addr];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         x0p_ff <= rd_x0[0];
         x1p_ff <= rd_x1[0];
         y0p_ff <= rd_y0[0];
         y1p_ff <= rd_y1[0];
      end
   end

   assign c00 = q_ff[{y0p_ff, x0p_ff}];
   assign c01 = q_ff[{y0p_ff, x1p_ff}];
   assign c10 = q_ff[{y1p_ff, x0p_ff}];
   assign c11 = q_ff[{y1p_ff, x1p_ff}];

endmodule

// ===== sv/bis_blend.sv =====
// ----------------------------------------------------------------------------
// bis_blend
// Two-stage bilinear blend: row blends, then the column blend into the
// output register of the result channel.
// ----------------------------------------------------------------------------
module bis_blend #(
   parameter int FRAC_BITS = bis_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [bis_pkg::PIX_W-1:0]     c00,
   input  logic [bis_pkg::PIX_W-1:0]     c01,
   input  logic [bis_pkg::PIX_W-1:0]     c10,
   input  logic [bis_pkg::PIX_W-1:0]     c11,
   input  logic [FRAC_BITS-1:0]          fx,
   input  logic [FRAC_BITS-1:0]          fy,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [bis_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   localparam int PW = bis_pkg::PIX_W;
   localparam int RW = FRAC_BITS + PW;
   localparam int SW = FRAC_BITS + PW + 2;
   localparam int VW = 2 * FRAC_BITS + PW + 2;

   logic                 row_en;
   logic                 out_en;
   logic                 row_valid_ff;
   logic [RW-1:0]        r0_ff;
   logic [RW-1:0]        r1_ff;
   logic [FRAC_BITS-1:0] fy_ff;
   logic                 out_valid_ff;
   logic [PW-1:0]        pix_ff;

   logic signed [PW:0]   d0;
   logic signed [PW:0]   d1;
   logic signed [SW-1:0] s0;
   logic signed [SW-1:0] s1;
   logic signed [RW:0]   e;
   logic signed [VW-1:0] v;

   assign out_en   = !out_valid_ff || rsp_tready;
   assign row_en   = !row_valid_ff || out_en;
   assign in_ready = row_en;

   always_comb begin
      d0 = $signed({1'b0, c01}) - $signed({1'b0, c00});
      d1 = $signed({1'b0, c11}) - $signed({1'b0, c10});
      s0 = $signed({2'b00, c00, {FRAC_BITS{1'b0}}}) + d0 * $signed({1'b0, fx});
      s1 = $signed({2'b00, c10, {FRAC_BITS{1'b0}}}) + d1 * $signed({1'b0, fx});
      e  = $signed({1'b0, r1_ff}) - $signed({1'b0, r0_ff});
      v  = $signed({2'b00, r0_ff, {FRAC_BITS{1'b0}}}) + e * $signed({1'b0, fy_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (row_en) begin
            row_valid_ff <= in_valid;
         end
         if (out_en) begin
            out_valid_ff <= row_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (row_en) begin
         r0_ff <= s0[RW-1:0];
         r1_ff <= s1[RW-1:0];
         fy_ff <= fy;
      end
      if (out_en) begin
         pix_ff <= v[2*FRAC_BITS+PW-1:2*FRAC_BITS];
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = pix_ff;

endmodule

// ===== sv/bilinear_image_scaler.sv =====
// ----------------------------------------------------------------------------
// bilinear_image_scaler
// Greyscale frame store with a bilinear sampler for image resizing.
// ----------------------------------------------------------------------------
// Items enter on the req_ stream. With tuser low an item loads one source
// pixel at (coord_x, coord_y) and gives no result; loads outside the
// configured source size are dropped. With tuser high an item requests the
// destination pixel at (coord_x, coord_y), returned on the rsp_ stream.
// The csr_ channel writes source width, height and the two Q9.16 steps; it
// is always ready and should be used only while no item is in flight.
// A sample result passes s1, s2, s3 and both blend registers before it
// shows on rsp_tvalid. One item is taken per cycle while req_tready is
// high: the frame store is split into four banks by row and column parity,
// so all four neighbors are read at once; loads write where samples read.
// When the result channel stalls, the pipeline fills up behind the output
// register and req_tready falls only once every stage holds an item.
// Reset clears the pipeline and restores the registers to 256, 256, 1.0 and
// 1.0; the frame store keeps no reset value and needs no clearing pass.
// ----------------------------------------------------------------------------
module bilinear_image_scaler #(
   parameter int MAX_SRC_DIM = bis_pkg::MAX_SRC_DIM_DEFAULT,
   parameter int MAX_DST_DIM = bis_pkg::MAX_DST_DIM_DEFAULT,
   parameter int FRAC_BITS   = bis_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   // req_tdata: coord_x [9:0], coord_y [19:10], pixel_in [27:20], zero pad.
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [bis_pkg::REQ_DATA_W-1:0]   req_tdata,
   // req_tuser: operation.
   input  logic                             req_tuser,
   // rsp_tdata: pixel_out [7:0].
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [bis_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [bis_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [bis_pkg::CSR_DATA_W-1:0]   csr_data
);

   localparam int CW    = bis_pkg::COORD_W;
   localparam int PXW   = bis_pkg::PIX_W;
   localparam int STW   = bis_pkg::STEP_W;
   localparam int DCFW  = bis_pkg::DIM_CFG_W;
   localparam int SW    = ($clog2(MAX_SRC_DIM) < 2) ? 2 : $clog2(MAX_SRC_DIM);
   localparam int POSW  = CW + STW;
   localparam int MSW   = $clog2(MAX_SRC_DIM + 1);
   localparam int DMW   = (MSW > DCFW) ? MSW : DCFW;
   localparam int OKW   = (CW > DMW) ? CW : DMW;
   localparam int MDW   = $clog2(MAX_DST_DIM + 1);
   localparam int DCW   = (MDW > CW) ? MDW : CW;

   logic [DCFW-1:0] src_width_ff;
   logic [DCFW-1:0] src_height_ff;
   logic [STW-1:0]  x_step_ff;
   logic [STW-1:0]  y_step_ff;

   logic [DMW-1:0]  w_eff;
   logic [DMW-1:0]  h_eff;
   logic [SW-1:0]   w_last;
   logic [SW-1:0]   h_last;

   logic [CW-1:0]   req_cx;
   logic [CW-1:0]   req_cy;
   logic [PXW-1:0]  req_pix;
   logic [DCW-1:0]  cx_ext;
   logic [DCW-1:0]  cy_ext;
   logic [CW-1:0]   cx_clamp;
   logic [CW-1:0]   cy_clamp;
   logic            load_ok;

   logic            en1;
   logic            en2;
   logic            en3;
   logic            blend_ready;

   logic            s1_valid_ff;
   logic            s1_op_ff;
   logic            s1_ok_ff;
   logic [SW-1:0]   s1_wx_ff;
   logic [SW-1:0]   s1_wy_ff;
   logic [PXW-1:0]  s1_pix_ff;
   logic [POSW-1:0] s1_posx_ff;
   logic [POSW-1:0] s1_posy_ff;

   logic            s2_valid_ff;
   logic            s2_op_ff;
   logic            s2_ok_ff;
   logic [SW-1:0]   s2_wx_ff;
   logic [SW-1:0]   s2_wy_ff;
   logic [PXW-1:0]  s2_pix_ff;

   logic [SW-1:0]        x0;
   logic [SW-1:0]        x1;
   logic [SW-1:0]        y0;
   logic [SW-1:0]        y1;
   logic [FRAC_BITS-1:0] fx;
   logic [FRAC_BITS-1:0] fy;

   logic                 s3_valid_ff;
   logic [FRAC_BITS-1:0] s3_fx_ff;
   logic [FRAC_BITS-1:0] s3_fy_ff;

   logic [PXW-1:0]  c00;
   logic [PXW-1:0]  c01;
   logic [PXW-1:0]  c10;
   logic [PXW-1:0]  c11;
   logic            store_wr;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= bis_pkg::SRC_WIDTH_RESET;
         src_height_ff <= bis_pkg::SRC_HEIGHT_RESET;
         x_step_ff     <= bis_pkg::X_STEP_RESET;
         y_step_ff     <= bis_pkg::Y_STEP_RESET;
      end else if (csr_valid) begin
         case (bis_pkg::csr_reg_type'(csr_index))
            bis_pkg::REG_SRC_WIDTH: begin
               src_width_ff <= csr_data[DCFW-1:0];
            end
            bis_pkg::REG_SRC_HEIGHT: begin
               src_height_ff <= csr_data[DCFW-1:0];
            end
            bis_pkg::REG_X_STEP: begin
               x_step_ff <= csr_data[STW-1:0];
            end
            bis_pkg::REG_Y_STEP: begin
               y_step_ff <= csr_data[STW-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (src_width_ff == '0) begin
         w_eff = DMW'(1);
      end else if (DMW'(src_width_ff) > DMW'(MAX_SRC_DIM)) begin
         w_eff = DMW'(MAX_SRC_DIM);
      end else begin
         w_eff = DMW'(src_width_ff);
      end
      if (src_height_ff == '0) begin
         h_eff = DMW'(1);
      end else if (DMW'(src_height_ff) > DMW'(MAX_SRC_DIM)) begin
         h_eff = DMW'(MAX_SRC_DIM);
      end else begin
         h_eff = DMW'(src_height_ff);
      end
      w_last = SW'(w_eff - DMW'(1));
      h_last = SW'(h_eff - DMW'(1));
   end

   always_comb begin
      req_cx  = req_tdata[CW-1:0];
      req_cy  = req_tdata[2*CW-1:CW];
      req_pix = req_tdata[2*CW+PXW-1:2*CW];
      cx_ext  = DCW'(req_cx);
      cy_ext  = DCW'(req_cy);
      if (cx_ext >= DCW'(MAX_DST_DIM)) begin
         cx_clamp = CW'(DCW'(MAX_DST_DIM) - DCW'(1));
      end else begin
         cx_clamp = req_cx;
      end
      if (cy_ext >= DCW'(MAX_DST_DIM)) begin
         cy_clamp = CW'(DCW'(MAX_DST_DIM) - DCW'(1));
      end else begin
         cy_clamp = req_cy;
      end
      load_ok = (OKW'(req_cx) < OKW'(w_eff)) && (OKW'(req_cy) < OKW'(h_eff));
   end

   assign en3        = !s3_valid_ff || blend_ready;
   assign en2        = !s2_valid_ff || en3;
   assign en1        = !s1_valid_ff || en2;
   assign req_tready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (en1) begin
            s1_valid_ff <= req_tvalid;
         end
         if (en2) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (en3) begin
            s3_valid_ff <= s2_valid_ff && (s2_op_ff == bis_pkg::OP_SAMPLE);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_op_ff   <= req_tuser;
         s1_ok_ff   <= load_ok;
         s1_wx_ff   <= SW'(req_cx);
         s1_wy_ff   <= SW'(req_cy);
         s1_pix_ff  <= req_pix;
         s1_posx_ff <= POSW'(cx_clamp) * POSW'(x_step_ff);
         s1_posy_ff <= POSW'(cy_clamp) * POSW'(y_step_ff);
      end
      if (en2) begin
         s2_op_ff  <= s1_op_ff;
         s2_ok_ff  <= s1_ok_ff;
         s2_wx_ff  <= s1_wx_ff;
         s2_wy_ff  <= s1_wy_ff;
         s2_pix_ff <= s1_pix_ff;
      end
      if (en3) begin
         s3_fx_ff <= fx;
         s3_fy_ff <= fy;
      end
   end

   bis_locate #(
      .POS_W     (POSW),
      .IDX_W     (SW),
      .FRAC_BITS (FRAC_BITS)
   ) u_locate_x (
      .clock (clock),
      .en    (en2),
      .pos   (s1_posx_ff),
      .last  (w_last),
      .base  (x0),
      .nxt   (x1),
      .frac  (fx)
   );

   bis_locate #(
      .POS_W     (POSW),
      .IDX_W     (SW),
      .FRAC_BITS (FRAC_BITS)
   ) u_locate_y (
      .clock (clock),
      .en    (en2),
      .pos   (s1_posy_ff),
      .last  (h_last),
      .base  (y0),
      .nxt   (y1),
      .frac  (fy)
   );

   assign store_wr = en3 && s2_valid_ff && (s2_op_ff == bis_pkg::OP_LOAD) && s2_ok_ff;

   bis_frame_store #(
      .IDX_W (SW)
   ) u_store (
      .clock   (clock),
      .rd_en   (en3),
      .rd_x0   (x0),
      .rd_x1   (x1),
      .rd_y0   (y0),
      .rd_y1   (y1),
      .wr_en   (store_wr),
      .wr_x    (s2_wx_ff),
      .wr_y    (s2_wy_ff),
      .wr_data (s2_pix_ff),
      .c00     (c00),
      .c01     (c01),
      .c10     (c10),
      .c11     (c11)
   );

   bis_blend #(
      .FRAC_BITS (FRAC_BITS)
   ) u_blend (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (s3_valid_ff),
      .in_ready   (blend_ready),
      .c00        (c00),
      .c01        (c01),
      .c10        (c10),
      .c11        (c11),
      .fx         (s3_fx_ff),
      .fy         (s3_fy_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
